// ===== rtl/core/csc_pkg.sv =====
// Shared types and constants for the cursor selection controller.
`default_nettype none

package csc_pkg;

  // Screen and image geometry.
  localparam int SCREEN_W = 640;
  localparam int SCREEN_H = 480;
  localparam int IMAGE_W  = 160;
  localparam int IMAGE_H  = 120;

  // Register widths for screen coordinates and the output fields.
  localparam int COL_W     = $clog2(SCREEN_W);
  localparam int ROW_W     = $clog2(SCREEN_H);
  localparam int IMG_COL_W = 8;
  localparam int IMG_ROW_W = 7;
  localparam int DELTA_W   = 11;
  localparam int LEVEL_W   = 3;
  localparam int CMD_W     = 4;
  localparam int CFG_IDX_W = 1;

  // Screen to image scaling is a right shift; both screen/image ratios are powers of two.
  localparam int COL_SHIFT = $clog2(SCREEN_W / IMAGE_W);
  localparam int ROW_SHIFT = $clog2(SCREEN_H / IMAGE_H);

  // Width of the signed sum of a screen coordinate and a move delta.
  localparam int POS_MAX_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int MOV_W     = ((POS_MAX_W > DELTA_W) ? POS_MAX_W : DELTA_W) + 2;

  // Zoom levels.
  localparam logic [LEVEL_W-1:0] LVL_IN4X   = 3'd0;
  localparam logic [LEVEL_W-1:0] LVL_IN2X   = 3'd1;
  localparam logic [LEVEL_W-1:0] LVL_DIRECT = 3'd2;
  localparam logic [LEVEL_W-1:0] LVL_OUT2X  = 3'd3;
  localparam logic [LEVEL_W-1:0] LVL_MAX    = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_IN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_OUT = 1'b1;

  typedef enum logic [2:0] {
    ACT_MOVE_X   = 3'd0,
    ACT_MOVE_Y   = 3'd1,
    ACT_LEFT     = 3'd2,
    ACT_RIGHT    = 3'd3,
    ACT_ZOOM_IN  = 3'd4,
    ACT_ZOOM_OUT = 3'd5,
    ACT_RESET    = 3'd6,
    ACT_APPLY    = 3'd7
  } action_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE      = 4'd0,
    CMD_IN2X_REP  = 4'd2,
    CMD_OUT2X_DEC = 4'd3,
    CMD_IN2X_NN   = 4'd4,
    CMD_OUT2X_AVG = 4'd5,
    CMD_DIRECT    = 4'd6,
    CMD_IN4X_REP  = 4'd7,
    CMD_OUT4X_DEC = 4'd8,
    CMD_IN4X_NN   = 4'd9,
    CMD_OUT4X_AVG = 4'd10
  } cmd_t;

  // One input event.
  typedef struct packed {
    action_t                    action;
    logic signed [DELTA_W-1:0]  delta;
    logic                       pressed;
  } event_t;

  // Selection and zoom part of a result.
  typedef struct packed {
    logic [IMG_COL_W-1:0] start_x;
    logic [IMG_ROW_W-1:0] start_y;
    logic [IMG_COL_W-1:0] end_x;
    logic [IMG_ROW_W-1:0] end_y;
    logic                 dragging;
    logic                 selected;
    logic                 cropped;
    logic [LEVEL_W-1:0]   zoom_level;
    cmd_t                 command_code;
    logic                 crop_apply;
  } sel_res_t;

  // Configuration registers as seen by the selection logic.
  typedef struct packed {
    logic zoom_in_method;
    logic zoom_out_method;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/csc_pos.sv =====
// Cursor position: screen accumulation with clamping and scaling to image coordinates.
`default_nettype none

module csc_pos
  import csc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 fire,
  input  wire event_t               ev,
  output logic [IMG_COL_W-1:0]      img_col,
  output logic [IMG_ROW_W-1:0]      img_row,
  output logic [IMG_COL_W-1:0]      img_col_nxt,
  output logic [IMG_ROW_W-1:0]      img_row_nxt
);

  localparam logic signed [MOV_W-1:0] SCR_W_S = MOV_W'(SCREEN_W);
  localparam logic signed [MOV_W-1:0] SCR_H_S = MOV_W'(SCREEN_H);

  logic [COL_W-1:0]           scr_col_r, scr_col_nxt;
  logic [ROW_W-1:0]           scr_row_r, scr_row_nxt;
  logic [IMG_COL_W-1:0]       img_col_r;
  logic [IMG_ROW_W-1:0]       img_row_r;
  logic signed [MOV_W-1:0]    delta_ext;
  logic signed [MOV_W-1:0]    col_sum;
  logic signed [MOV_W-1:0]    row_sum;
  logic [COL_W-1:0]           col_scaled;
  logic [ROW_W-1:0]           row_scaled;
  logic                       is_move;

  assign delta_ext = MOV_W'(ev.delta);
  assign col_sum   = $signed(MOV_W'(scr_col_r)) + delta_ext;
  assign row_sum   = $signed(MOV_W'(scr_row_r)) + delta_ext;

  always_comb begin
    scr_col_nxt = scr_col_r;
    scr_row_nxt = scr_row_r;
    if (ev.action == ACT_MOVE_X) begin
      if (col_sum < 0) begin
        scr_col_nxt = '0;
      end else if (col_sum >= SCR_W_S) begin
        scr_col_nxt = COL_W'(SCREEN_W - 1);
      end else begin
        scr_col_nxt = col_sum[COL_W-1:0];
      end
    end
    if (ev.action == ACT_MOVE_Y) begin
      if (row_sum < 0) begin
        scr_row_nxt = '0;
      end else if (row_sum >= SCR_H_S) begin
        scr_row_nxt = ROW_W'(SCREEN_H - 1);
      end else begin
        scr_row_nxt = row_sum[ROW_W-1:0];
      end
    end
  end

  // Scale the new screen position; any move recomputes both axes.
  assign is_move    = (ev.action == ACT_MOVE_X) || (ev.action == ACT_MOVE_Y);
  assign col_scaled = scr_col_nxt >> COL_SHIFT;
  assign row_scaled = scr_row_nxt >> ROW_SHIFT;

  always_comb begin
    img_col_nxt = img_col_r;
    img_row_nxt = img_row_r;
    if (is_move) begin
      if (COL_W'(col_scaled) >= COL_W'(IMAGE_W)) begin
        img_col_nxt = IMG_COL_W'(IMAGE_W - 1);
      end else begin
        img_col_nxt = IMG_COL_W'(col_scaled);
      end
      if (ROW_W'(row_scaled) >= ROW_W'(IMAGE_H)) begin
        img_row_nxt = IMG_ROW_W'(IMAGE_H - 1);
      end else begin
        img_row_nxt = IMG_ROW_W'(row_scaled);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_col_r <= COL_W'(SCREEN_W / 2);
      scr_row_r <= ROW_W'(SCREEN_H / 2);
      img_col_r <= IMG_COL_W'(IMAGE_W / 2);
      img_row_r <= IMG_ROW_W'(IMAGE_H / 2);
    end else if (fire) begin
      scr_col_r <= scr_col_nxt;
      scr_row_r <= scr_row_nxt;
      img_col_r <= img_col_nxt;
      img_row_r <= img_row_nxt;
    end
  end

  assign img_col = img_col_r;
  assign img_row = img_row_r;

endmodule

`default_nettype wire

// ===== rtl/core/csc_sel.sv =====
// Selection drag, crop and zoom level state with command code generation.
`default_nettype none

module csc_sel
  import csc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 fire,
  input  wire event_t               ev,
  input  wire cfg_t                 cfg,
  input  wire logic [IMG_COL_W-1:0] img_col,
  input  wire logic [IMG_ROW_W-1:0] img_row,
  output sel_res_t                  res
);

  logic [IMG_COL_W-1:0] start_x_r, start_x_nxt;
  logic [IMG_ROW_W-1:0] start_y_r, start_y_nxt;
  logic [IMG_COL_W-1:0] end_x_r, end_x_nxt;
  logic [IMG_ROW_W-1:0] end_y_r, end_y_nxt;
  logic                 drag_r, drag_nxt;
  logic                 sel_r, sel_nxt;
  logic                 crop_r, crop_nxt;
  logic                 left_r, left_nxt;
  logic [LEVEL_W-1:0]   level_r, level_nxt;
  cmd_t                 cmd;
  logic                 apply;
  logic                 free_sel;

  function automatic cmd_t level_cmd(input logic [LEVEL_W-1:0] lv, input cfg_t c);
    cmd_t code;
    unique case (lv)
      LVL_IN4X:   code = c.zoom_in_method  ? CMD_IN4X_NN   : CMD_IN4X_REP;
      LVL_IN2X:   code = c.zoom_in_method  ? CMD_IN2X_NN   : CMD_IN2X_REP;
      LVL_DIRECT: code = CMD_DIRECT;
      LVL_OUT2X:  code = c.zoom_out_method ? CMD_OUT2X_AVG : CMD_OUT2X_DEC;
      LVL_MAX:    code = c.zoom_out_method ? CMD_OUT4X_AVG : CMD_OUT4X_DEC;
      default:    code = CMD_NONE;
    endcase
    return code;
  endfunction

  assign free_sel = (level_r == LVL_DIRECT) && !crop_r;

  always_comb begin
    start_x_nxt = start_x_r;
    start_y_nxt = start_y_r;
    end_x_nxt   = end_x_r;
    end_y_nxt   = end_y_r;
    drag_nxt    = drag_r;
    sel_nxt     = sel_r;
    crop_nxt    = crop_r;
    left_nxt    = left_r;
    level_nxt   = level_r;
    cmd         = CMD_NONE;
    apply       = 1'b0;
    unique case (ev.action)
      ACT_MOVE_X, ACT_MOVE_Y: begin
      end
      ACT_LEFT: begin
        // Only an edge of the left button changes the selection.
        if (free_sel) begin
          if (ev.pressed && !left_r) begin
            start_x_nxt = img_col;
            start_y_nxt = img_row;
            drag_nxt    = 1'b1;
          end else if (!ev.pressed && left_r) begin
            end_x_nxt = img_col;
            end_y_nxt = img_row;
            drag_nxt  = 1'b0;
            sel_nxt   = 1'b1;
          end
        end
        left_nxt = ev.pressed;
      end
      ACT_RIGHT: begin
        if (ev.pressed && free_sel) begin
          sel_nxt  = 1'b0;
          drag_nxt = 1'b0;
        end
      end
      ACT_ZOOM_IN: begin
        if (level_r > LVL_IN4X && level_r <= LVL_MAX) begin
          level_nxt = level_r - 3'd1;
          cmd       = level_cmd(level_nxt, cfg);
        end
      end
      ACT_ZOOM_OUT: begin
        if (level_r < LVL_MAX) begin
          level_nxt = level_r + 3'd1;
          cmd       = level_cmd(level_nxt, cfg);
        end
      end
      ACT_RESET: begin
        sel_nxt   = 1'b0;
        drag_nxt  = 1'b0;
        crop_nxt  = 1'b0;
        level_nxt = LVL_DIRECT;
        cmd       = level_cmd(LVL_DIRECT, cfg);
      end
      ACT_APPLY: begin
        if (free_sel && sel_r) begin
          crop_nxt = 1'b1;
          sel_nxt  = 1'b0;
          drag_nxt = 1'b0;
          apply    = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      end_x_r   <= '0;
      end_y_r   <= '0;
      drag_r    <= 1'b0;
      sel_r     <= 1'b0;
      crop_r    <= 1'b0;
      left_r    <= 1'b0;
      level_r   <= LVL_DIRECT;
    end else if (fire) begin
      start_x_r <= start_x_nxt;
      start_y_r <= start_y_nxt;
      end_x_r   <= end_x_nxt;
      end_y_r   <= end_y_nxt;
      drag_r    <= drag_nxt;
      sel_r     <= sel_nxt;
      crop_r    <= crop_nxt;
      left_r    <= left_nxt;
      level_r   <= level_nxt;
    end
  end

  always_comb begin
    res.start_x      = start_x_nxt;
    res.start_y      = start_y_nxt;
    res.end_x        = end_x_nxt;
    res.end_y        = end_y_nxt;
    res.dragging     = drag_nxt;
    res.selected     = sel_nxt;
    res.cropped      = crop_nxt;
    res.zoom_level   = level_nxt;
    res.command_code = cmd;
    res.crop_apply   = apply;
  end

endmodule

`default_nettype wire

// ===== rtl/core/cursor_selection_controller.sv =====
// An accepted item waits in the input register until fire retires it into the result register.
// Throughput: one item per cycle while results are taken; the input and result registers each
// hold one item, and the event logic between them updates all cursor and selection state at fire.
// Reset (rst_n low, synchronous) centers the cursor, clears drag, selection and crop, sets
// zoom level to direct copy, zeroes both method registers and empties both item registers.
`default_nettype none

module cursor_selection_controller
  import csc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2:0]            in_action,
  input  wire logic signed [DELTA_W-1:0] in_delta,
  input  wire logic                  in_pressed,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [IMG_COL_W-1:0]       out_cursor_x,
  output logic [IMG_ROW_W-1:0]       out_cursor_y,
  output logic [IMG_COL_W-1:0]       out_start_x,
  output logic [IMG_ROW_W-1:0]       out_start_y,
  output logic [IMG_COL_W-1:0]       out_end_x,
  output logic [IMG_ROW_W-1:0]       out_end_y,
  output logic                       out_dragging,
  output logic                       out_selected,
  output logic                       out_cropped,
  output logic [LEVEL_W-1:0]         out_zoom_level,
  output logic [CMD_W-1:0]           out_command_code,
  output logic                       out_crop_apply,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic                  cfg_data
);

  // The input register holds one accepted item until the event logic can
  // retire it into the result register. An item is retired (fire) whenever
  // the result register is empty or is being emptied in the same cycle.
  // While a finished result waits, the input register can still take one
  // more item; after that the input stalls until the result is taken.
  logic                 in_vld_r, in_vld_nxt;
  event_t               ev_r;
  logic                 out_vld_r, out_vld_nxt;
  logic                 fire;
  cfg_t                 cfg_r, cfg_nxt;

  logic [IMG_COL_W-1:0] img_col, img_col_nxt;
  logic [IMG_ROW_W-1:0] img_row, img_row_nxt;
  sel_res_t             sel_res;

  logic [IMG_COL_W-1:0] cur_x_r;
  logic [IMG_ROW_W-1:0] cur_y_r;
  sel_res_t             res_r;

  assign fire       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready   = !in_vld_r || fire;
  assign in_vld_nxt = (in_valid && in_ready) ? 1'b1 : (fire ? 1'b0 : in_vld_r);
  assign out_vld_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Item payload: loaded on acceptance only.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev_r.action  <= action_t'(in_action);
      ev_r.delta   <= in_delta;
      ev_r.pressed <= in_pressed;
    end
  end

  // Method registers. The user must write them only while the block is idle; the block does
  // not enforce this, and the port is always ready.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ZOOM_IN:  cfg_nxt.zoom_in_method  = cfg_data;
        CFG_ZOOM_OUT: cfg_nxt.zoom_out_method = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Cursor accumulation and scaling.
  csc_pos u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .ev          (ev_r),
    .img_col     (img_col),
    .img_row     (img_row),
    .img_col_nxt (img_col_nxt),
    .img_row_nxt (img_row_nxt)
  );

  // Selection, crop and zoom. Button events capture the cursor as it stands
  // before the event, which a button event never moves.
  csc_sel u_sel (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .ev      (ev_r),
    .cfg     (cfg_r),
    .img_col (img_col),
    .img_row (img_row),
    .res     (sel_res)
  );

  // Result register: payload loads with each retired item.
  always_ff @(posedge clk) begin
    if (fire) begin
      cur_x_r <= img_col_nxt;
      cur_y_r <= img_row_nxt;
      res_r   <= sel_res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_cursor_x     = cur_x_r;
  assign out_cursor_y     = cur_y_r;
  assign out_start_x      = res_r.start_x;
  assign out_start_y      = res_r.start_y;
  assign out_end_x        = res_r.end_x;
  assign out_end_y        = res_r.end_y;
  assign out_dragging     = res_r.dragging;
  assign out_selected     = res_r.selected;
  assign out_cropped      = res_r.cropped;
  assign out_zoom_level   = res_r.zoom_level;
  assign out_command_code = res_r.command_code;
  assign out_crop_apply   = res_r.crop_apply;

  // The zoom level never leaves its range.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_zoom_level <= LVL_MAX))
    else $error("zoom level out of range");

  // A cropped image holds neither a drag nor a selection.
  a_crop_clears_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_cropped) |-> (!out_dragging && !out_selected))
    else $error("selection state left while cropped");

  // An applied crop marks the image cropped and issues no zoom command.
  a_apply_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_crop_apply) |-> (out_cropped && out_command_code == CMD_NONE))
    else $error("crop apply inconsistent");

  // The cursor stays inside the image.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cursor_x < IMG_COL_W'(IMAGE_W) && out_cursor_y < IMG_ROW_W'(IMAGE_H)))
    else $error("cursor outside image");

  // A retired item always leaves a result behind it.
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("retired item produced no result");

endmodule

`default_nettype wire

// ===== bench/cursor_selection_controller_tb.sv =====
// Self-checking testbench for the cursor selection controller: directed events, then random ones.
`timescale 1ns / 100ps

module cursor_selection_controller_tb;
  import csc_pkg::*;

  // Cycles without any handshake on any channel before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 300;
  localparam int unsigned MAX_REPORTS = 10;

  // One result item, laid out as the block presents it.
  typedef struct packed {
    logic [IMG_COL_W-1:0] cursor_x;
    logic [IMG_ROW_W-1:0] cursor_y;
    logic [IMG_COL_W-1:0] start_x;
    logic [IMG_ROW_W-1:0] start_y;
    logic [IMG_COL_W-1:0] end_x;
    logic [IMG_ROW_W-1:0] end_y;
    logic                 dragging;
    logic                 selected;
    logic                 cropped;
    logic [LEVEL_W-1:0]   zoom_level;
    cmd_t                 command_code;
    logic                 crop_apply;
  } frame_t;

  // One row of the directed sequence. Where typed is set, want holds the result read off by
  // hand; otherwise the result comes from the predictor below.
  typedef struct packed {
    action_t                   act;
    logic signed [DELTA_W-1:0] delta;
    logic                      pressed;
    logic                      typed;
    frame_t                    want;
  } drill_row_t;

  localparam frame_t NO_FRAME = '0;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_CHOPPY,
    SINK_SLOW
  } sink_mode_t;

  // Clock, reset and the block's inputs, all known from time zero.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic [2:0]                in_action = ACT_MOVE_X;
  logic signed [DELTA_W-1:0] in_delta = '0;
  logic                      in_pressed = 1'b0;
  logic                      out_ready = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = CFG_ZOOM_IN;
  logic                      cfg_data = 1'b0;

  logic                 in_ready;
  logic                 out_valid;
  logic [IMG_COL_W-1:0] out_cursor_x;
  logic [IMG_ROW_W-1:0] out_cursor_y;
  logic [IMG_COL_W-1:0] out_start_x;
  logic [IMG_ROW_W-1:0] out_start_y;
  logic [IMG_COL_W-1:0] out_end_x;
  logic [IMG_ROW_W-1:0] out_end_y;
  logic                 out_dragging;
  logic                 out_selected;
  logic                 out_cropped;
  logic [LEVEL_W-1:0]   out_zoom_level;
  logic [CMD_W-1:0]     out_command_code;
  logic                 out_crop_apply;
  logic                 cfg_ready;

  cursor_selection_controller u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_delta         (in_delta),
    .in_pressed       (in_pressed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cursor_x     (out_cursor_x),
    .out_cursor_y     (out_cursor_y),
    .out_start_x      (out_start_x),
    .out_start_y      (out_start_y),
    .out_end_x        (out_end_x),
    .out_end_y        (out_end_y),
    .out_dragging     (out_dragging),
    .out_selected     (out_selected),
    .out_cropped      (out_cropped),
    .out_zoom_level   (out_zoom_level),
    .out_command_code (out_command_code),
    .out_crop_apply   (out_crop_apply),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------------
  // Predictor state. It starts at the reset values of the block, and the method registers are
  // mirrored when their writes are accepted.
  // ---------------------------------------------------------------------------------------------
  logic                 zin_method = 1'b0;
  logic                 zout_method = 1'b0;
  logic [COL_W-1:0]     scr_col = COL_W'(SCREEN_W / 2);
  logic [ROW_W-1:0]     scr_row = ROW_W'(SCREEN_H / 2);
  logic [IMG_COL_W-1:0] img_col = IMG_COL_W'(IMAGE_W / 2);
  logic [IMG_ROW_W-1:0] img_row = IMG_ROW_W'(IMAGE_H / 2);
  logic                 left_down = 1'b0;
  logic [IMG_COL_W-1:0] anchor_col = '0;
  logic [IMG_ROW_W-1:0] anchor_row = '0;
  logic [IMG_COL_W-1:0] corner_col = '0;
  logic [IMG_ROW_W-1:0] corner_row = '0;
  logic                 drag_on = 1'b0;
  logic                 sel_held = 1'b0;
  logic                 crop_done = 1'b0;
  logic [LEVEL_W-1:0]   lvl = LVL_DIRECT;

  // Results the block still owes, oldest first.
  frame_t expected_frames[$];

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left = 0;

  // The algorithm command that entering a zoom level issues under the current methods.
  function automatic cmd_t zoom_cmd(input logic [LEVEL_W-1:0] lv);
    case (lv)
      LVL_IN4X:   return zin_method ? CMD_IN4X_NN : CMD_IN4X_REP;
      LVL_IN2X:   return zin_method ? CMD_IN2X_NN : CMD_IN2X_REP;
      LVL_DIRECT: return CMD_DIRECT;
      LVL_OUT2X:  return zout_method ? CMD_OUT2X_AVG : CMD_OUT2X_DEC;
      LVL_MAX:    return zout_method ? CMD_OUT4X_AVG : CMD_OUT4X_DEC;
      default:    return CMD_NONE;
    endcase
  endfunction

  // Applies one event to the predictor state and returns the result the block must produce.
  task automatic track_event(input action_t act, input logic signed [DELTA_W-1:0] d,
                             input logic p, output frame_t f);
    int   pos;
    int   img;
    logic free_sel;
    cmd_t cmd;
    logic apply;
    free_sel = (lvl == LVL_DIRECT) && !crop_done;
    cmd = CMD_NONE;
    apply = 1'b0;
    case (act)
      ACT_MOVE_X, ACT_MOVE_Y: begin
        // Accumulate on the screen grid with clamping, then rescale both image coordinates.
        if (act == ACT_MOVE_X) begin
          pos = int'(scr_col) + int'(d);
          pos = (pos < 0) ? 0 : (pos >= SCREEN_W) ? SCREEN_W - 1 : pos;
          scr_col = COL_W'(pos);
        end else begin
          pos = int'(scr_row) + int'(d);
          pos = (pos < 0) ? 0 : (pos >= SCREEN_H) ? SCREEN_H - 1 : pos;
          scr_row = ROW_W'(pos);
        end
        img = (int'(scr_col) * IMAGE_W) / SCREEN_W;
        img_col = IMG_COL_W'((img >= IMAGE_W) ? IMAGE_W - 1 : img);
        img = (int'(scr_row) * IMAGE_H) / SCREEN_H;
        img_row = IMG_ROW_W'((img >= IMAGE_H) ? IMAGE_H - 1 : img);
      end
      ACT_LEFT: begin
        // Only a press or release edge at direct copy on an uncropped image moves the
        // selection; the button memory follows every left event.
        if (free_sel) begin
          if (p && !left_down) begin
            anchor_col = img_col;
            anchor_row = img_row;
            drag_on = 1'b1;
          end else if (!p && left_down) begin
            corner_col = img_col;
            corner_row = img_row;
            drag_on = 1'b0;
            sel_held = 1'b1;
          end
        end
        left_down = p;
      end
      ACT_RIGHT: begin
        if (p && free_sel) begin
          sel_held = 1'b0;
          drag_on = 1'b0;
        end
      end
      ACT_ZOOM_IN: begin
        if (lvl > LVL_IN4X) begin
          lvl = lvl - 1'b1;
          cmd = zoom_cmd(lvl);
        end
      end
      ACT_ZOOM_OUT: begin
        if (lvl < LVL_MAX) begin
          lvl = lvl + 1'b1;
          cmd = zoom_cmd(lvl);
        end
      end
      ACT_RESET: begin
        // The cursor and the button memory survive the reset key.
        sel_held = 1'b0;
        drag_on = 1'b0;
        crop_done = 1'b0;
        lvl = LVL_DIRECT;
        cmd = zoom_cmd(lvl);
      end
      default: begin
        if (free_sel && sel_held) begin
          crop_done = 1'b1;
          sel_held = 1'b0;
          drag_on = 1'b0;
          apply = 1'b1;
        end
      end
    endcase
    f = '{img_col, img_row, anchor_col, anchor_row, corner_col, corner_row,
          drag_on, sel_held, crop_done, lvl, cmd, apply};
  endtask

  function automatic string differing_fields(input frame_t want, input frame_t seen);
    string s = "";
    if (seen.cursor_x !== want.cursor_x) s = {s, " cursor_x"};
    if (seen.cursor_y !== want.cursor_y) s = {s, " cursor_y"};
    if (seen.start_x !== want.start_x) s = {s, " start_x"};
    if (seen.start_y !== want.start_y) s = {s, " start_y"};
    if (seen.end_x !== want.end_x) s = {s, " end_x"};
    if (seen.end_y !== want.end_y) s = {s, " end_y"};
    if (seen.dragging !== want.dragging) s = {s, " dragging"};
    if (seen.selected !== want.selected) s = {s, " selected"};
    if (seen.cropped !== want.cropped) s = {s, " cropped"};
    if (seen.zoom_level !== want.zoom_level) s = {s, " zoom_level"};
    if (seen.command_code !== want.command_code) s = {s, " command_code"};
    if (seen.crop_apply !== want.crop_apply) s = {s, " crop_apply"};
    return s;
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Directed sequence: screen extremes in both axes, a full drag, repeated edges, a cancel, an
  // apply and a repeated apply, left edges while cropped and away from direct copy, both zoom
  // limits, the reset key and an apply with nothing selected. The first four rows start from the
  // centered reset cursor, so their results are written out by hand.
  // ---------------------------------------------------------------------------------------------
  drill_row_t drill [28] = '{
    '{ACT_MOVE_X,    11'sd1023, 1'b0, 1'b1,
      '{8'd159, 7'd60, 8'd0, 7'd0, 8'd0, 7'd0, 1'b0, 1'b0, 1'b0, LVL_DIRECT, CMD_NONE, 1'b0}},
    '{ACT_MOVE_X,   -11'sd1024, 1'b1, 1'b1,
      '{8'd0, 7'd60, 8'd0, 7'd0, 8'd0, 7'd0, 1'b0, 1'b0, 1'b0, LVL_DIRECT, CMD_NONE, 1'b0}},
    '{ACT_MOVE_Y,    11'sd1023, 1'b0, 1'b1,
      '{8'd0, 7'd119, 8'd0, 7'd0, 8'd0, 7'd0, 1'b0, 1'b0, 1'b0, LVL_DIRECT, CMD_NONE, 1'b0}},
    '{ACT_MOVE_Y,   -11'sd1024, 1'b1, 1'b1,
      '{8'd0, 7'd0, 8'd0, 7'd0, 8'd0, 7'd0, 1'b0, 1'b0, 1'b0, LVL_DIRECT, CMD_NONE, 1'b0}},
    '{ACT_MOVE_X,    11'sd400,  1'b0, 1'b0, NO_FRAME},
    '{ACT_MOVE_Y,    11'sd200,  1'b0, 1'b0, NO_FRAME},
    '{ACT_LEFT,     -11'sd1,    1'b1, 1'b0, NO_FRAME},
    '{ACT_LEFT,      11'sd0,    1'b1, 1'b0, NO_FRAME},
    '{ACT_MOVE_X,    11'sd100,  1'b0, 1'b0, NO_FRAME},
    '{ACT_LEFT,      11'sd1023, 1'b0, 1'b0, NO_FRAME},
    '{ACT_LEFT,      11'sd0,    1'b0, 1'b0, NO_FRAME},
    '{ACT_RIGHT,     11'sd0,    1'b1, 1'b0, NO_FRAME},
    '{ACT_LEFT,      11'sd0,    1'b1, 1'b0, NO_FRAME},
    '{ACT_LEFT,      11'sd0,    1'b0, 1'b0, NO_FRAME},
    '{ACT_APPLY,     11'sd5,    1'b0, 1'b0, NO_FRAME},
    '{ACT_APPLY,     11'sd0,    1'b1, 1'b0, NO_FRAME},
    '{ACT_LEFT,      11'sd0,    1'b1, 1'b0, NO_FRAME},
    '{ACT_ZOOM_IN,  -11'sd1024, 1'b0, 1'b0, NO_FRAME},
    '{ACT_ZOOM_IN,   11'sd0,    1'b1, 1'b0, NO_FRAME},
    '{ACT_ZOOM_IN,   11'sd0,    1'b0, 1'b0, NO_FRAME},
    '{ACT_LEFT,      11'sd0,    1'b0, 1'b0, NO_FRAME},
    '{ACT_ZOOM_OUT,  11'sd0,    1'b0, 1'b0, NO_FRAME},
    '{ACT_ZOOM_OUT,  11'sd0,    1'b0, 1'b0, NO_FRAME},
    '{ACT_ZOOM_OUT,  11'sd0,    1'b0, 1'b0, NO_FRAME},
    '{ACT_ZOOM_OUT,  11'sd0,    1'b0, 1'b0, NO_FRAME},
    '{ACT_ZOOM_OUT,  11'sd1023, 1'b1, 1'b0, NO_FRAME},
    '{ACT_RESET,     11'sd0,    1'b1, 1'b0, NO_FRAME},
    '{ACT_APPLY,     11'sd0,    1'b0, 1'b0, NO_FRAME}
  };

  // ---------------------------------------------------------------------------------------------
  // Input side. Items go out in bursts of random length; between bursts valid drops for a random
  // gap, and a third of the bursts follow their predecessor with no gap at all. Valid is lowered
  // only when a real gap follows, so it never gets two updates in one time step.
  // ---------------------------------------------------------------------------------------------
  task automatic send_event(input action_t act, input logic signed [DELTA_W-1:0] d,
                            input logic p, input logic typed, input frame_t typed_frame);
    frame_t predicted;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= act;
    in_delta <= d;
    in_pressed <= p;
    do @(posedge clk); while (!in_ready);
    // The item was taken at this edge, so the predictor moves on now.
    track_event(act, d, p, predicted);
    expected_frames.push_back(typed ? typed_frame : predicted);
  endtask

  // Random events lean toward what gets deep into the selection logic: plenty of short moves,
  // left events that mostly flip the button so drags begin and end, and enough zoom and reset
  // keys that the level keeps coming back to direct copy where selections are allowed.
  task automatic next_random_event(output action_t act, output logic signed [DELTA_W-1:0] d,
                                   output logic p);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) act = pick[0] ? ACT_MOVE_X : ACT_MOVE_Y;
    else if (pick < 62) act = ACT_LEFT;
    else if (pick < 70) act = ACT_RIGHT;
    else if (pick < 78) act = ACT_ZOOM_IN;
    else if (pick < 86) act = ACT_ZOOM_OUT;
    else if (pick < 91) act = ACT_RESET;
    else act = ACT_APPLY;
    // Mostly small steps so the cursor wanders; now and then any delta, which also pins
    // the cursor against the screen edges.
    if ($urandom_range(0, 7) == 0) d = DELTA_W'($urandom);
    else d = DELTA_W'(int'($urandom_range(0, 160)) - 80);
    if (act == ACT_LEFT && $urandom_range(0, 4) != 0) p = !left_down;
    else p = 1'($urandom_range(0, 1));
  endtask

  // Both method registers are written in one pass; valid stays high between the two items.
  task automatic load_methods(input logic zin, input logic zout);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ZOOM_IN;
    cfg_data <= zin;
    do @(posedge clk); while (!cfg_ready);
    zin_method = zin;
    cfg_index <= CFG_ZOOM_OUT;
    cfg_data <= zout;
    do @(posedge clk); while (!cfg_ready);
    zout_method = zout;
    cfg_valid <= 1'b0;
  endtask

  // Stops sending and waits until every owed result is in.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------------------
  // Output side. The receiver switches at random between modes of its own:
  // always ready, ready at random half the time, and mostly stalled.
  // ---------------------------------------------------------------------------------------------
  sink_mode_t  sink_mode = SINK_OPEN;
  int unsigned mode_left = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      sink_mode <= sink_mode_t'($urandom_range(0, 2));
      mode_left <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (sink_mode)
      SINK_OPEN:   out_ready <= 1'b1;
      SINK_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
      default:     out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Every accepted result is matched against the oldest owed one.
  always @(posedge clk) begin : check_results
    frame_t seen;
    frame_t want;
    if (rst_n && out_valid && out_ready) begin
      seen = '{out_cursor_x, out_cursor_y, out_start_x, out_start_y, out_end_x, out_end_y,
               out_dragging, out_selected, out_cropped, out_zoom_level,
               cmd_t'(out_command_code), out_crop_apply};
      results_seen++;
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d arrived with nothing owed: %p", results_seen, seen);
      end else begin
        want = expected_frames.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d differs in%s\n  expected %p\n  actual   %p",
                     results_seen, differing_fields(want, seen), want, seen);
        end
      end
    end
  end

  // A hung handshake ends the run: count cycles in which no channel moves an item.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------------------------
  // Main sequence: reset, directed rows with both methods at zero, then four random phases that
  // walk the method registers through every combination, each written while the block is idle.
  // ---------------------------------------------------------------------------------------------
  initial begin : stimulus
    action_t                   act;
    logic signed [DELTA_W-1:0] d;
    logic                      p;
    logic [1:0]                phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_methods(1'b0, 1'b0);
    foreach (drill[i])
      send_event(drill[i].act, drill[i].delta, drill[i].pressed, drill[i].typed, drill[i].want);

    phase = 2'd0;
    do begin
      settle();
      // Phases in order: both methods set, zoom-in method cleared, zoom-out method cleared,
      // both cleared.
      load_methods(!phase[0], !phase[1]);
      repeat (PHASE_ITEMS) begin
        next_random_event(act, d, p);
        send_event(act, d, p, 1'b0, NO_FRAME);
      end
      phase = phase + 1'b1;
    end while (phase != 2'd0);

    settle();
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
